// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition that must hold in the cycle after reset.
`define ASSERT_RST(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/m3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types, constants and cofactor index tables of the 3x3 inverse.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int ELEM_W_DEF    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FIELD_W       = 32;
  localparam int THR_W         = 31;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_THRESHOLD = 1'b0;

  typedef logic [3:0] idx_t;

  // cofactor i = m[A]*m[B] - m[C]*m[D]
  localparam idx_t CF_A [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam idx_t CF_B [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam idx_t CF_C [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam idx_t CF_D [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  // determinant = m0*cf0 + m1*cf3 + m2*cf6
  localparam idx_t DET_CF [3] = '{4'd0, 4'd3, 4'd6};

endpackage

// ===== rtl/m3inv_if.sv =====
// ----------------------------------------------------------------------------
// m3inv_mat_if / m3inv_res_if
// Valid/ready channels for the input matrix and the result beat.
// ----------------------------------------------------------------------------
interface m3inv_mat_if import m3inv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface m3inv_res_if import m3inv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic               singular;
  logic               overflow;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, overflow, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, overflow, output ready);
endinterface

// ===== rtl/m3inv_div.sv =====
// ----------------------------------------------------------------------------
// m3inv_div
// Pipelined restoring divider: one quotient bit per stage, plus a range check.
// ----------------------------------------------------------------------------
module m3inv_div import m3inv_pkg::*; #(
  parameter int NUM_W = 97,
  parameter int DEN_W = 99,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic [Q_W:0]     adv,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             big
);

  localparam int HW   = NUM_W - Q_W;
  localparam int CMPW = ((HW > DEN_W) ? HW : DEN_W) + 1;

  logic [DEN_W-1:0] rem  [Q_W+1];
  logic [DEN_W-1:0] dn   [Q_W+1];
  logic [Q_W-1:0]   lo   [Q_W+1];
  logic [Q_W-1:0]   qq   [Q_W+1];
  logic             bg   [Q_W+1];

  // stage 0: quotient of 2^Q_W or more saturates anyway
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      bg[0]  <= CMPW'(num[NUM_W-1:Q_W]) >= CMPW'(den);
      rem[0] <= DEN_W'(num[NUM_W-1:Q_W]);
      lo[0]  <= num[Q_W-1:0];
      dn[0]  <= den;
      qq[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
      trial = {rem[k-1], lo[k-1][Q_W-1]};
      diff  = trial - {1'b0, dn[k-1]};
      ge    = trial >= {1'b0, dn[k-1]};
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo[k]  <= lo[k-1] << 1;
        qq[k]  <= {qq[k-1][Q_W-2:0], ge};
        dn[k]  <= dn[k-1];
        bg[k]  <= bg[k-1];
      end
    end
  end

  assign quo = qq[Q_W];
  assign big = bg[Q_W];

endmodule

// ===== rtl/matrix3_inverse_fixed.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse_fixed
// Inverse of a 3x3 signed fixed-point matrix by the adjugate.
// ----------------------------------------------------------------------------
// Usage:
//   mat carries one matrix per beat (m00..m22, signed Q16.16 by default);
//   inv returns one beat per matrix in the same order: r00..r22, singular
//   and overflow. A singular matrix (|det| below the threshold, or zero) is
//   echoed with singular set. Otherwise each element is cofactor << 2*FRAC
//   divided by det, truncated toward zero and saturated (overflow set).
//   The APB port holds singular_threshold at address 0 (reset value 1).
//   The pipeline is six stages of products, cofactors and determinant,
//   ELEMENT_WIDTH + 1 stages of nine parallel dividers at one quotient
//   bit per stage, and the output register. Throughput is one matrix per
//   cycle while inv does not stall; the divider chain sets the depth,
//   not the rate.
//   Reset (rst, synchronous) empties the pipeline and restores the threshold.
//   When inv stalls, each stage holds only if the stage after it is full,
//   so bubbles close up and mat.ready drops only when every stage is full.
// ----------------------------------------------------------------------------
module matrix3_inverse_fixed import m3inv_pkg::*; #(
  parameter int ELEMENT_WIDTH = ELEM_W_DEF,
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  m3inv_mat_if.sink             mat,
  m3inv_res_if.source           inv
);

  localparam int E    = ELEMENT_WIDTH;
  localparam int PW   = 2 * E;
  localparam int CW   = 2 * E + 1;
  localparam int DETW = 3 * E + 3;
  localparam int NW   = CW + 2 * FRACTION_BITS;
  localparam int TCW  = ((DETW > THR_W + 2 * FRACTION_BITS) ? DETW
                         : THR_W + 2 * FRACTION_BITS) + 1;
  localparam int DS   = 6;          // first divider stage
  localparam int S    = E + 8;      // total stages, last is the output reg

  localparam logic [E-1:0] LIM_POS = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] LIM_NEG = {1'b1, {(E-1){1'b0}}};

  // ---------------- configuration ----------------
  logic [THR_W-1:0] thr;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_THRESHOLD;
  assign prdata  = reg_hit ? APB_DATA_W'(thr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      thr <= pwdata[THR_W-1:0];
    end
  end

  // ---------------- flow control ----------------
  // stage k moves when it is empty or the stage after it moves
  logic [S-1:0] vld;
  logic [S-1:0] adv;

  always_comb begin
    adv[S-1] = !vld[S-1] || inv.ready;
    for (int k = S - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign mat.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= mat.valid;
      end
      for (int k = 1; k < S; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------- input elements ----------------
  logic signed [E-1:0] ein [9];

  always_comb begin
    ein[0] = $signed(mat.m00[E-1:0]);
    ein[1] = $signed(mat.m01[E-1:0]);
    ein[2] = $signed(mat.m02[E-1:0]);
    ein[3] = $signed(mat.m10[E-1:0]);
    ein[4] = $signed(mat.m11[E-1:0]);
    ein[5] = $signed(mat.m12[E-1:0]);
    ein[6] = $signed(mat.m20[E-1:0]);
    ein[7] = $signed(mat.m21[E-1:0]);
    ein[8] = $signed(mat.m22[E-1:0]);
  end

  // stage 0: eighteen element products
  logic signed [PW-1:0] pab [9];
  logic signed [PW-1:0] pcd [9];
  logic signed [E-1:0]  e0  [9];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 9; i++) begin
        pab[i] <= ein[CF_A[i]] * ein[CF_B[i]];
        pcd[i] <= ein[CF_C[i]] * ein[CF_D[i]];
        e0[i]  <= ein[i];
      end
    end
  end

  // stage 1: cofactors
  logic signed [CW-1:0] cf1 [9];
  logic signed [E-1:0]  e1  [9];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 9; i++) begin
        cf1[i] <= CW'(pab[i]) - CW'(pcd[i]);
      end
      e1 <= e0;
    end
  end

  // stage 2: first-row element times cofactor, split into low and high halves
  logic signed [2*E:0]  plo [3];
  logic signed [2*E:0]  phi [3];
  logic signed [CW-1:0] cf2 [9];
  logic signed [E-1:0]  e2  [9];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int j = 0; j < 3; j++) begin
        plo[j] <= e1[j] * $signed({1'b0, cf1[DET_CF[j]][E-1:0]});
        phi[j] <= e1[j] * $signed(cf1[DET_CF[j]][CW-1:E]);
      end
      cf2 <= cf1;
      e2  <= e1;
    end
  end

  // stage 3: recombine the halves
  logic signed [DETW-1:0] term [3];
  logic signed [CW-1:0]   cf3  [9];
  logic signed [E-1:0]    e3   [9];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int j = 0; j < 3; j++) begin
        term[j] <= (DETW'(phi[j]) <<< E) + DETW'(plo[j]);
      end
      cf3 <= cf2;
      e3  <= e2;
    end
  end

  // stage 4: determinant
  logic signed [DETW-1:0] det4;
  logic signed [CW-1:0]   cf4 [9];
  logic signed [E-1:0]    e4  [9];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      det4 <= term[0] + term[1] + term[2];
      cf4  <= cf3;
      e4   <= e3;
    end
  end

  // stage 5: magnitudes, signs and the singular test
  logic [DETW-1:0] det_abs;
  logic [TCW-1:0]  thr_sh;
  logic [CW-1:0]   cf_abs [9];

  always_comb begin
    det_abs = det4[DETW-1] ? DETW'(-det4) : DETW'(det4);
    thr_sh  = TCW'(thr) << (2 * FRACTION_BITS);
    for (int i = 0; i < 9; i++) begin
      cf_abs[i] = cf4[i][CW-1] ? CW'(-cf4[i]) : CW'(cf4[i]);
    end
  end

  logic [DETW-1:0]     adet5;
  logic                sing5;
  logic [8:0]          neg5;
  logic [NW-1:0]       num5 [9];
  logic signed [E-1:0] e5   [9];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      adet5 <= det_abs;
      sing5 <= (det_abs == '0) || (TCW'(det_abs) < thr_sh);
      for (int i = 0; i < 9; i++) begin
        neg5[i] <= cf4[i][CW-1] ^ det4[DETW-1];
        num5[i] <= {cf_abs[i], {(2 * FRACTION_BITS){1'b0}}};
      end
      e5 <= e4;
    end
  end

  // stages DS .. DS+E: nine dividers with the side data riding alongside
  logic [E-1:0] quo [9];
  logic [8:0]   big;

  for (genvar i = 0; i < 9; i++) begin : g_div
    m3inv_div #(
      .NUM_W (NW),
      .DEN_W (DETW),
      .Q_W   (E)
    ) u_div (
      .clk (clk),
      .adv (adv[DS+E:DS]),
      .num (num5[i]),
      .den (adet5),
      .quo (quo[i]),
      .big (big[i])
    );
  end

  logic signed [E-1:0] sb_e    [E+1][9];
  logic                sb_sing [E+1];
  logic [8:0]          sb_neg  [E+1];

  always_ff @(posedge clk) begin
    if (adv[DS]) begin
      sb_e[0]    <= e5;
      sb_sing[0] <= sing5;
      sb_neg[0]  <= neg5;
    end
  end

  for (genvar k = 1; k <= E; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv[DS+k]) begin
        sb_e[k]    <= sb_e[k-1];
        sb_sing[k] <= sb_sing[k-1];
        sb_neg[k]  <= sb_neg[k-1];
      end
    end
  end

  // output stage: saturate, apply sign, or echo a singular matrix
  logic [E-1:0]       lim  [9];
  logic [E-1:0]       mag  [9];
  logic [E-1:0]       res  [9];
  logic [8:0]         sat;
  logic [FIELD_W-1:0] r_next [9];
  logic               ovf_next;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      lim[i] = sb_neg[E][i] ? LIM_NEG : LIM_POS;
      sat[i] = big[i] || (quo[i] > lim[i]);
      mag[i] = sat[i] ? lim[i] : quo[i];
      res[i] = sb_neg[E][i] ? E'(-mag[i]) : mag[i];
      r_next[i] = sb_sing[E] ? FIELD_W'(sb_e[E][i]) : FIELD_W'($signed(res[i]));
    end
    ovf_next = !sb_sing[E] && (sat != '0);
  end

  logic [FIELD_W-1:0] r_out [9];
  logic               sing_out;
  logic               ovf_out;

  always_ff @(posedge clk) begin
    if (adv[S-1]) begin
      r_out    <= r_next;
      sing_out <= sb_sing[E];
      ovf_out  <= ovf_next;
    end
  end

  assign inv.valid    = vld[S-1];
  assign inv.r00      = r_out[0];
  assign inv.r01      = r_out[1];
  assign inv.r02      = r_out[2];
  assign inv.r10      = r_out[3];
  assign inv.r11      = r_out[4];
  assign inv.r12      = r_out[5];
  assign inv.r20      = r_out[6];
  assign inv.r21      = r_out[7];
  assign inv.r22      = r_out[8];
  assign inv.singular = sing_out;
  assign inv.overflow = ovf_out;

endmodule

// ===== rtl/m3inv_checker.sv =====
// ----------------------------------------------------------------------------
// m3inv_checker
// Port-level checks of the 3x3 inverse, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module m3inv_checker import m3inv_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               inv_valid,
  input logic               inv_ready,
  input logic [FIELD_W-1:0] inv_r00,
  input logic               inv_singular,
  input logic               inv_overflow
);

  `ASSERT_IMP(a_sing_no_ovf, clk, rst, inv_valid, !(inv_singular && inv_overflow))
  `ASSERT_NXT(a_stall_hold, clk, rst, inv_valid && !inv_ready, inv_valid && $stable(inv_r00) && $stable(inv_singular))
  `ASSERT_RST(a_reset_empty, clk, rst, !inv_valid)
  `ASSERT_IMP(a_pready, clk, rst, 1'b1, pready)

endmodule

bind matrix3_inverse_fixed m3inv_checker u_m3inv_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .inv_valid    (inv.valid),
  .inv_ready    (inv.ready),
  .inv_r00      (inv.r00),
  .inv_singular (inv.singular),
  .inv_overflow (inv.overflow)
);
